FILE: sv/tfs_pkg.sv
package tfs_pkg;

   // Frame geometry.
   localparam int unsigned FRAME_BYTES  = 32;
   localparam int unsigned SENSOR_BYTES = 20;
   localparam int unsigned SENSOR_BITS  = SENSOR_BYTES * 8;
   localparam int unsigned IDX_W        = $clog2(FRAME_BYTES);

   // Byte positions inside a frame.
   localparam logic [IDX_W-1:0] IDX_SYNC0     = 5'd0;
   localparam logic [IDX_W-1:0] IDX_SYNC1     = 5'd1;
   localparam logic [IDX_W-1:0] IDX_TYPE      = 5'd2;
   localparam logic [IDX_W-1:0] IDX_MSG       = 5'd3;
   localparam logic [IDX_W-1:0] IDX_SENS_LO   = 5'd4;
   localparam logic [IDX_W-1:0] IDX_SENS_HI   = 5'd23;
   localparam logic [IDX_W-1:0] IDX_FILL_LO   = 5'd24;
   localparam logic [IDX_W-1:0] IDX_FILL_HI   = 5'd27;
   localparam logic [IDX_W-1:0] IDX_SUM_SPAN  = 5'd30;
   localparam logic [IDX_W-1:0] IDX_CHECKSUM  = 5'd31;

   // Frame byte values.
   localparam logic [7:0] SYNC0_BYTE   = 8'hA5;
   localparam logic [7:0] SYNC1_BYTE   = 8'h5A;
   localparam logic [7:0] TYPE_DATA    = 8'h10;
   localparam logic [7:0] TYPE_STATUS  = 8'h20;
   localparam logic [7:0] FILL_BYTE    = 8'hFF;
   localparam logic [7:0] ZERO_BYTE    = 8'h00;

   // Result kinds.
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_CTRL = 1'b1;

   // Register map.
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_SEND_THRESHOLD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_PER_STATUS = 1'd1;

   localparam logic [7:0] SEND_THRESHOLD_RESET = 8'd10;
   localparam logic [2:0] DATA_PER_STATUS_RESET = 3'd5;

   // Frame sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FRAME,
      ST_CTRL
   } tfs_state_type;

   // Tick command from the scheduler to the frame sequencer.
   typedef struct packed {
      logic       accept;
      logic       send;
      logic       is_status;
      logic [7:0] msg;
      logic       clear_status;
      logic       tx_flush;
      logic       chip_enable;
   } tfs_start_type;

endpackage

FILE: sv/tfs_req_if.sv
interface tfs_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] temperature;
   logic signed [31:0] altitude;
   logic        [31:0] pressure;
   logic signed [31:0] angle_x_centi;
   logic signed [31:0] angle_y_centi;
   logic               retry_limit_hit;
   logic               tx_fifo_full;

   modport source (
      output valid, temperature, altitude, pressure, angle_x_centi, angle_y_centi,
             retry_limit_hit, tx_fifo_full,
      input  ready
   );

   modport sink (
      input  valid, temperature, altitude, pressure, angle_x_centi, angle_y_centi,
             retry_limit_hit, tx_fifo_full,
      output ready
   );
endinterface

FILE: sv/tfs_rsp_if.sv
interface tfs_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] payload_byte;
   logic [4:0] byte_index;
   logic       clear_status;
   logic       tx_flush;
   logic       chip_enable;
   logic       last;

   modport source (
      output valid, kind, payload_byte, byte_index, clear_status, tx_flush,
             chip_enable, last,
      input  ready
   );

   modport sink (
      input  valid, kind, payload_byte, byte_index, clear_status, tx_flush,
             chip_enable, last,
      output ready
   );
endinterface

FILE: sv/telemetry_frame_scheduler_core.sv
// Channel  Direction  Contents
// req_ch   in         sensor samples and radio flags of one tick
// rsp_ch   out        frame bytes, then one control result per tick
// csr_*    in         register writes (send threshold, data frames per status)
//
// A tick that sends a frame yields 33 results, one per cycle while rsp_ch is
// ready; the next tick is taken once the control result sits in the output
// register, so no new tick is taken while a frame is under way.
// The rate is set by the byte-wide frame sequencer and sensor shift register.
// Reset is synchronous and active high; it restores the register defaults.
// A stall on rsp_ch holds the current result and pauses the frame sequencer.
module telemetry_frame_scheduler_core (
   input  logic                           clock,
   input  logic                           reset,
   tfs_req_if.sink                        req_ch,
   tfs_rsp_if.source                      rsp_ch,
   input  logic                           csr_we,
   input  logic [tfs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tfs_pkg::CSR_DATA_W-1:0] csr_wdata
);

   logic [7:0] threshold_ff;
   logic [2:0] per_status_ff;
   logic [7:0] tick_ff, tick_in;
   logic       enable_done_ff;
   logic       status_next_ff, status_next_in;
   logic [2:0] data_count_ff, data_count_in;
   logic [7:0] msg_ff, msg_in;

   logic                   idle_ready;
   logic                   accept;
   logic                   send;
   logic                   is_status;
   logic                   load_sensors;
   logic                   sensor_shift;
   logic [7:0]             sensor_byte;
   logic [2:0]             data_count_inc;
   tfs_pkg::tfs_start_type start;

   assign req_ch.ready = idle_ready;
   assign accept       = req_ch.valid && idle_ready;

   // Scheduling decision for the tick being taken.
   assign send           = tick_ff > threshold_ff;
   assign is_status      = status_next_ff;
   assign load_sensors   = accept && send && !status_next_ff;
   assign data_count_inc = data_count_ff + 1'b1;

   always_comb begin
      tick_in        = tick_ff;
      msg_in         = msg_ff;
      status_next_in = status_next_ff;
      data_count_in  = data_count_ff;
      if (accept) begin
         tick_in = send ? 8'd1 : tick_ff + 1'b1;
         if (send) begin
            msg_in = msg_ff + 1'b1;
            if (status_next_ff) begin
               status_next_in = 1'b0;
            end else if (data_count_inc >= per_status_ff) begin
               data_count_in  = '0;
               status_next_in = 1'b1;
            end else begin
               data_count_in = data_count_inc;
            end
         end
      end
   end

   always_comb begin
      start.accept       = accept;
      start.send         = send;
      start.is_status    = is_status;
      start.msg          = msg_ff;
      start.clear_status = req_ch.retry_limit_hit;
      start.tx_flush     = req_ch.tx_fifo_full;
      start.chip_enable  = send || !enable_done_ff;
   end

   // Registers and scheduling state.
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff   <= tfs_pkg::SEND_THRESHOLD_RESET;
         per_status_ff  <= tfs_pkg::DATA_PER_STATUS_RESET;
         tick_ff        <= '0;
         enable_done_ff <= 1'b0;
         status_next_ff <= 1'b0;
         data_count_ff  <= '0;
         msg_ff         <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               tfs_pkg::CSR_SEND_THRESHOLD:  threshold_ff  <= csr_wdata;
               tfs_pkg::CSR_DATA_PER_STATUS: per_status_ff <= csr_wdata[2:0];
               default:                      threshold_ff  <= threshold_ff;
            endcase
         end
         tick_ff        <= tick_in;
         msg_ff         <= msg_in;
         status_next_ff <= status_next_in;
         data_count_ff  <= data_count_in;
         if (accept) begin
            enable_done_ff <= 1'b1;
         end
      end
   end

   tfs_sensor_shreg u_shreg (
      .clock     (clock),
      .load      (load_sensors),
      .load_data ({req_ch.angle_y_centi, req_ch.angle_x_centi, req_ch.pressure,
                   req_ch.altitude, req_ch.temperature}),
      .shift     (sensor_shift),
      .head_byte (sensor_byte)
   );

   tfs_frame_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .sensor_byte  (sensor_byte),
      .idle_ready   (idle_ready),
      .sensor_shift (sensor_shift),
      .rsp          (rsp_ch)
   );

   // After an accepted tick the counter is non-zero, unless it wrapped past 255.
   a_tick_nonzero: assert property (@(posedge clock) disable iff (reset)
      accept |=> tick_ff != '0)
      else $error("tick counter zero after a tick");

   // A status frame is never scheduled back to back with another status frame.
   a_status_alternates: assert property (@(posedge clock) disable iff (reset)
      (accept && send && status_next_ff) |=> !status_next_ff)
      else $error("status frame flag not cleared");

   // After each data frame the count stays below a non-zero frames-per-status setting.
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      (accept && send && !status_next_ff && per_status_ff != '0)
      |=> data_count_ff < $past(per_status_ff))
      else $error("data frame count out of range");

endmodule

FILE: sv/tfs_sensor_shreg.sv
module tfs_sensor_shreg (
   input  logic                             clock,
   input  logic                             load,
   input  logic [tfs_pkg::SENSOR_BITS-1:0]  load_data,
   input  logic                             shift,
   output logic [7:0]                       head_byte
);

   logic [tfs_pkg::SENSOR_BITS-1:0] bytes_ff;
   logic [tfs_pkg::SENSOR_BITS-1:0] bytes_in;

   // Load a new sensor set, or rotate one byte so that the held set returns
   // to its original order after a full frame.
   always_comb begin
      bytes_in = bytes_ff;
      if (load) begin
         bytes_in = load_data;
      end else if (shift) begin
         bytes_in = {bytes_ff[7:0], bytes_ff[tfs_pkg::SENSOR_BITS-1:8]};
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
   end

   assign head_byte = bytes_ff[7:0];

endmodule

FILE: sv/tfs_frame_ctrl.sv
module tfs_frame_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  tfs_pkg::tfs_start_type start,
   input  logic [7:0]            sensor_byte,
   output logic                  idle_ready,
   output logic                  sensor_shift,
   tfs_rsp_if.source             rsp
);

   tfs_pkg::tfs_state_type state_ff, state_in;

   logic [tfs_pkg::IDX_W-1:0] cnt_ff, cnt_in;
   logic [7:0]                sum_ff, sum_in;
   logic                      status_ff;
   logic [7:0]                msg_ff;
   logic                      clr_ff, fl_ff, ce_ff;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      kind_ff;
   logic [7:0]                byte_ff;
   logic [tfs_pkg::IDX_W-1:0] index_ff;
   logic                      clr_out_ff, fl_out_ff, ce_out_ff, last_ff;

   logic                      advance;
   logic                      load_byte;
   logic                      load_ctrl;
   logic                      start_frame;
   logic [7:0]                frame_byte;
   logic                      ctrl_clr, ctrl_fl, ctrl_ce;

   // The output register can take a new result when empty or being drained.
   assign advance = !rsp_valid_ff || rsp.ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tfs_pkg::ST_IDLE: begin
            if (start.accept && start.send) begin
               state_in = tfs_pkg::ST_FRAME;
            end
         end
         tfs_pkg::ST_FRAME: begin
            if (advance && cnt_ff == tfs_pkg::IDX_CHECKSUM) begin
               state_in = tfs_pkg::ST_CTRL;
            end
         end
         tfs_pkg::ST_CTRL: begin
            if (advance) begin
               state_in = tfs_pkg::ST_IDLE;
            end
         end
         default: state_in = tfs_pkg::ST_IDLE;
      endcase
   end

   // Control outputs of the sequencer.
   always_comb begin
      idle_ready  = 1'b0;
      load_byte   = 1'b0;
      load_ctrl   = 1'b0;
      start_frame = 1'b0;
      ctrl_clr    = clr_ff;
      ctrl_fl     = fl_ff;
      ctrl_ce     = ce_ff;
      unique case (state_ff)
         tfs_pkg::ST_IDLE: begin
            idle_ready = advance;
            if (start.accept) begin
               start_frame = start.send;
               load_ctrl   = !start.send;
               ctrl_clr    = start.clear_status;
               ctrl_fl     = start.tx_flush;
               ctrl_ce     = start.chip_enable;
            end
         end
         tfs_pkg::ST_FRAME: begin
            load_byte = advance;
         end
         tfs_pkg::ST_CTRL: begin
            load_ctrl = advance;
         end
         default: begin
            idle_ready = 1'b0;
         end
      endcase
   end

   // Frame byte for the current position.
   always_comb begin
      case (cnt_ff) inside
         tfs_pkg::IDX_SYNC0:                          frame_byte = tfs_pkg::SYNC0_BYTE;
         tfs_pkg::IDX_SYNC1:                          frame_byte = tfs_pkg::SYNC1_BYTE;
         tfs_pkg::IDX_TYPE:
            frame_byte = status_ff ? tfs_pkg::TYPE_STATUS : tfs_pkg::TYPE_DATA;
         tfs_pkg::IDX_MSG:                            frame_byte = msg_ff;
         [tfs_pkg::IDX_SENS_LO:tfs_pkg::IDX_SENS_HI]: frame_byte = sensor_byte;
         [tfs_pkg::IDX_FILL_LO:tfs_pkg::IDX_FILL_HI]: frame_byte = tfs_pkg::FILL_BYTE;
         tfs_pkg::IDX_CHECKSUM:                       frame_byte = sum_ff;
         default:                                     frame_byte = tfs_pkg::ZERO_BYTE;
      endcase
   end

   assign sensor_shift = load_byte &&
                         cnt_ff >= tfs_pkg::IDX_SENS_LO && cnt_ff <= tfs_pkg::IDX_SENS_HI;

   // Byte counter and running checksum, one byte per transfer.
   always_comb begin
      cnt_in = cnt_ff;
      sum_in = sum_ff;
      if (start_frame) begin
         cnt_in = '0;
         sum_in = '0;
      end else if (load_byte) begin
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff < tfs_pkg::IDX_SUM_SPAN) begin
            sum_in = sum_ff + frame_byte;
         end
      end
   end

   assign rsp_valid_in = load_byte || load_ctrl || (rsp_valid_ff && !rsp.ready);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tfs_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Running checksum, and frame header and tick flags captured when a tick is taken.
   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      if (start.accept) begin
         status_ff <= start.is_status;
         msg_ff    <= start.msg;
         clr_ff    <= start.clear_status;
         fl_ff     <= start.tx_flush;
         ce_ff     <= start.chip_enable;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (load_byte) begin
         kind_ff    <= tfs_pkg::KIND_BYTE;
         byte_ff    <= frame_byte;
         index_ff   <= cnt_ff;
         clr_out_ff <= 1'b0;
         fl_out_ff  <= 1'b0;
         ce_out_ff  <= 1'b0;
         last_ff    <= 1'b0;
      end else if (load_ctrl) begin
         kind_ff    <= tfs_pkg::KIND_CTRL;
         byte_ff    <= tfs_pkg::ZERO_BYTE;
         index_ff   <= '0;
         clr_out_ff <= ctrl_clr;
         fl_out_ff  <= ctrl_fl;
         ce_out_ff  <= ctrl_ce;
         last_ff    <= 1'b1;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.kind         = kind_ff;
   assign rsp.payload_byte = byte_ff;
   assign rsp.byte_index   = index_ff;
   assign rsp.clear_status = clr_out_ff;
   assign rsp.tx_flush     = fl_out_ff;
   assign rsp.chip_enable  = ce_out_ff;
   assign rsp.last         = last_ff;

   // The byte counter rests at zero between frames.
   a_idle_cnt_zero: assert property (@(posedge clock) disable iff (reset)
      state_ff == tfs_pkg::ST_IDLE |-> cnt_ff == '0)
      else $error("byte counter not at zero while idle");

   // While the control result is pending, the checksum byte is still held.
   a_ctrl_holds_output: assert property (@(posedge clock) disable iff (reset)
      state_ff == tfs_pkg::ST_CTRL |-> rsp_valid_ff)
      else $error("output register empty while control result pending");

   // The checksum byte is loaded as the final frame byte.
   a_checksum_last_byte: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tfs_pkg::ST_FRAME && advance && cnt_ff == tfs_pkg::IDX_CHECKSUM)
      |=> (state_ff == tfs_pkg::ST_CTRL && index_ff == tfs_pkg::IDX_CHECKSUM))
      else $error("checksum byte not at the end of the frame");

endmodule

FILE: bench/telemetry_frame_scheduler_core_tb.sv
`timescale 1ns / 1ps

module telemetry_frame_scheduler_core_tb;

   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int NUM_PHASES = 9;

   // One tick as the sender holds it until its transfer.
   typedef struct {
      logic signed [31:0] temperature;
      logic signed [31:0] altitude;
      logic        [31:0] pressure;
      logic signed [31:0] angle_x_centi;
      logic signed [31:0] angle_y_centi;
      logic               retry_limit_hit;
      logic               tx_fifo_full;
      bit                 wait_for_drain;
   } sensor_tick_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] payload_byte;
      logic [4:0] byte_index;
      logic       clear_status;
      logic       tx_flush;
      logic       chip_enable;
      logic       last;
   } frame_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                           csr_we = 1'b0;
   logic [tfs_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [tfs_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   tfs_req_if req_ch ();
   tfs_rsp_if rsp_ch ();

   telemetry_frame_scheduler_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Ticks waiting to be sent and frame results waiting to arrive.
   sensor_tick_type  ticks_to_send[$];
   frame_result_type frame_results_due[$];

   // Register copies as last written.
   logic [7:0] cfg_threshold = tfs_pkg::SEND_THRESHOLD_RESET;
   logic [2:0] cfg_per_status = tfs_pkg::DATA_PER_STATUS_RESET;

   // Scheduler state as the block should hold it.
   logic [7:0] ticks_since_send = 8'd0;
   logic       radio_enabled = 1'b0;
   logic       status_due = 1'b0;
   logic [2:0] data_since_status = 3'd0;
   logic [7:0] msg_number = 8'd0;
   logic [7:0] held_bytes [tfs_pkg::SENSOR_BYTES];

   int mismatch_count = 0;
   int results_promised = 0;
   int results_checked = 0;
   int ticks_accepted = 0;
   int data_frames = 0;
   int status_frames = 0;
   int msg_wraps = 0;
   int settings_used = 0;
   int cycle_count = 0;
   int send_gap = 0;
   int take_stall = 0;
   bit send_fast = 1'b0;
   bit take_fast = 1'b0;

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 20) begin
         $display("[%0t] MISMATCH: %s", $time, what);
      end
   endtask

   function automatic int draw_idle(input bit fast);
      return fast ? 0 : $urandom_range(0, 15);
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 9))
         0: pick_word = 32'h0000_0000;
         1: pick_word = 32'hFFFF_FFFF;
         2: pick_word = 32'h8000_0000;
         3: pick_word = 32'h7FFF_FFFF;
         default: pick_word = $urandom();
      endcase
   endfunction

   // Works out the frame bytes and the control result that one tick causes.
   task automatic predict_tick(input sensor_tick_type t);
      logic [7:0]                      frame [tfs_pkg::FRAME_BYTES];
      logic [7:0]                      sum;
      logic [tfs_pkg::SENSOR_BITS-1:0] words;
      frame_result_type                r;
      ticks_accepted++;
      if (ticks_since_send > cfg_threshold) begin
         frame[tfs_pkg::IDX_SYNC0] = tfs_pkg::SYNC0_BYTE;
         frame[tfs_pkg::IDX_SYNC1] = tfs_pkg::SYNC1_BYTE;
         frame[tfs_pkg::IDX_MSG] = msg_number;
         if (!status_due) begin
            // A data frame latches fresh sensor bytes, little-endian per word.
            frame[tfs_pkg::IDX_TYPE] = tfs_pkg::TYPE_DATA;
            words = {t.angle_y_centi, t.angle_x_centi, t.pressure, t.altitude,
                     t.temperature};
            for (int i = 0; i < tfs_pkg::SENSOR_BYTES; i++) begin
               held_bytes[i] = words[8*i +: 8];
            end
            data_since_status = data_since_status + 3'd1;
            if (data_since_status >= cfg_per_status) begin
               data_since_status = 3'd0;
               status_due = 1'b1;
            end
            data_frames++;
         end else begin
            // A status frame repeats the bytes of the last data frame.
            frame[tfs_pkg::IDX_TYPE] = tfs_pkg::TYPE_STATUS;
            status_due = 1'b0;
            status_frames++;
         end
         for (int i = 0; i < tfs_pkg::SENSOR_BYTES; i++) begin
            frame[int'(tfs_pkg::IDX_SENS_LO) + i] = held_bytes[i];
         end
         for (int i = tfs_pkg::IDX_FILL_LO; i <= tfs_pkg::IDX_FILL_HI; i++) begin
            frame[i] = tfs_pkg::FILL_BYTE;
         end
         for (int i = tfs_pkg::IDX_FILL_HI + 1; i < tfs_pkg::FRAME_BYTES - 1; i++) begin
            frame[i] = tfs_pkg::ZERO_BYTE;
         end
         sum = 8'd0;
         for (int i = 0; i < tfs_pkg::IDX_SUM_SPAN; i++) begin
            sum = sum + frame[i];
         end
         frame[tfs_pkg::IDX_CHECKSUM] = sum;
         for (int i = 0; i < tfs_pkg::FRAME_BYTES; i++) begin
            r = '{kind: tfs_pkg::KIND_BYTE, payload_byte: frame[i], byte_index: i[4:0],
                  clear_status: 1'b0, tx_flush: 1'b0, chip_enable: 1'b0, last: 1'b0};
            frame_results_due.push_back(r);
         end
         results_promised += tfs_pkg::FRAME_BYTES;
         ticks_since_send = 8'd0;
         if (msg_number == 8'hFF) begin
            msg_wraps++;
         end
         msg_number = msg_number + 8'd1;
         radio_enabled = 1'b0;
      end
      // Every tick closes with a control result; chip enable is set on the first tick and on every send.
      r = '{kind: tfs_pkg::KIND_CTRL, payload_byte: 8'd0, byte_index: 5'd0,
            clear_status: t.retry_limit_hit, tx_flush: t.tx_fifo_full,
            chip_enable: !radio_enabled, last: 1'b1};
      frame_results_due.push_back(r);
      results_promised++;
      radio_enabled = 1'b1;
      ticks_since_send = ticks_since_send + 8'd1;
   endtask

   // Tick driver: presents queued ticks with random gaps between transfers.
   always @(posedge clock) begin : tick_driver
      sensor_tick_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_tick(ticks_to_send.pop_front());
            send_gap = draw_idle(send_fast);
            if ($urandom_range(0, 39) == 0) begin
               send_fast = !send_fast;
            end
         end else if (!req_ch.valid && send_gap > 0) begin
            send_gap--;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap == 0 && ticks_to_send.size() > 0 &&
                (!ticks_to_send[0].wait_for_drain ||
                 results_checked >= results_promised)) begin
               nxt = ticks_to_send[0];
               req_ch.valid           <= 1'b1;
               req_ch.temperature     <= nxt.temperature;
               req_ch.altitude        <= nxt.altitude;
               req_ch.pressure        <= nxt.pressure;
               req_ch.angle_x_centi   <= nxt.angle_x_centi;
               req_ch.angle_y_centi   <= nxt.angle_y_centi;
               req_ch.retry_limit_hit <= nxt.retry_limit_hit;
               req_ch.tx_fifo_full    <= nxt.tx_fifo_full;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: stalls at random and checks each transfer in order.
   always @(posedge clock) begin : result_monitor
      frame_result_type want;
      string            bad;
      string            got_text;
      string            want_text;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         take_stall = draw_idle(take_fast);
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            bad = "";
            if (frame_results_due.size() == 0) begin
               report_mismatch($sformatf("unexpected result: kind %0d byte %02h index %0d",
                                         rsp_ch.kind, rsp_ch.payload_byte,
                                         rsp_ch.byte_index));
            end else begin
               want = frame_results_due.pop_front();
               if (rsp_ch.kind !== want.kind) bad = {bad, " kind"};
               if (rsp_ch.payload_byte !== want.payload_byte) bad = {bad, " payload_byte"};
               if (rsp_ch.byte_index !== want.byte_index) bad = {bad, " byte_index"};
               if (rsp_ch.clear_status !== want.clear_status) bad = {bad, " clear_status"};
               if (rsp_ch.tx_flush !== want.tx_flush) bad = {bad, " tx_flush"};
               if (rsp_ch.chip_enable !== want.chip_enable) bad = {bad, " chip_enable"};
               if (rsp_ch.last !== want.last) bad = {bad, " last"};
               if (bad != "") begin
                  got_text = $sformatf("%0d/%02h/%0d/%b%b%b/%b",
                     rsp_ch.kind, rsp_ch.payload_byte, rsp_ch.byte_index,
                     rsp_ch.clear_status, rsp_ch.tx_flush, rsp_ch.chip_enable,
                     rsp_ch.last);
                  want_text = $sformatf("%0d/%02h/%0d/%b%b%b/%b",
                     want.kind, want.payload_byte, want.byte_index, want.clear_status,
                     want.tx_flush, want.chip_enable, want.last);
                  report_mismatch($sformatf("result %0d wrong in%s: got %s want %s",
                                            results_checked, bad, got_text, want_text));
               end
            end
            results_checked <= results_checked + 1;
            take_stall = draw_idle(take_fast);
            if ($urandom_range(0, 39) == 0) begin
               take_fast = !take_fast;
            end
         end else if (take_stall > 0) begin
            take_stall--;
         end
         rsp_ch.ready <= (take_stall == 0);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles, %0d results still outstanding.",
                  cycle_count, frame_results_due.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Returns once every queued tick has transferred and every result is back.
   task automatic wait_idle();
      while (ticks_to_send.size() != 0 || req_ch.valid || frame_results_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (8) @(negedge clock);
   endtask

   task automatic write_registers(input logic [7:0] threshold, input logic [2:0] per_status);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= tfs_pkg::CSR_SEND_THRESHOLD;
      csr_wdata <= threshold;
      @(posedge clock);
      csr_index <= tfs_pkg::CSR_DATA_PER_STATUS;
      csr_wdata <= {5'd0, per_status};
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_threshold = threshold;
      cfg_per_status = per_status;
      settings_used++;
   endtask

   initial begin : stimulus
      sensor_tick_type t;
      logic [31:0]     corner_words [11];
      logic [7:0]      phase_threshold [NUM_PHASES];
      logic [2:0]      phase_per_status [NUM_PHASES];
      int              phase_ticks [NUM_PHASES];
      req_ch.valid = 1'b0;
      req_ch.temperature = '0;
      req_ch.altitude = '0;
      req_ch.pressure = '0;
      req_ch.angle_x_centi = '0;
      req_ch.angle_y_centi = '0;
      req_ch.retry_limit_hit = 1'b0;
      req_ch.tx_fifo_full = 1'b0;
      rsp_ch.ready = 1'b0;
      // The eighth entry lands on a status tick, so its value is not sent.
      corner_words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                       32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678,
                       32'h00FF_00FF, 32'hFF00_FF00, 32'hFFFF_FFFE};
      // Threshold 255 never sends; the seventh phase gets random settings.
      phase_threshold  = '{8'd0, 8'd255, 8'd1, 8'd0, 8'd3, 8'd0, 8'd0, 8'd0, 8'd10};
      phase_per_status = '{3'd7, 3'd1, 3'd1, 3'd3, 3'd6, 3'd1, 3'd1, 3'd5, 3'd5};
      phase_ticks      = '{50, 20, 40, 50, 40, 50, 40, 50, 40};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part: the first tick is quiet and pulses chip enable, then
      // seven data frames of corner words, a status frame and more data.
      write_registers(8'd0, 3'd7);
      t = '{default: '0};
      ticks_to_send.push_back(t);
      for (int i = 0; i < 11; i++) begin
         t.temperature = corner_words[i];
         t.altitude = corner_words[i];
         t.pressure = ~corner_words[i];
         t.angle_x_centi = corner_words[i];
         t.angle_y_centi = corner_words[i];
         t.retry_limit_hit = i[0];
         t.tx_fifo_full = i[1];
         t.wait_for_drain = (i == 9);
         ticks_to_send.push_back(t);
      end
      // Distinct bytes everywhere show the byte order of each word.
      t = '{temperature: 32'h1312_1110, altitude: 32'h2322_2120, pressure: 32'h3332_3130,
            angle_x_centi: 32'h4342_4140, angle_y_centi: 32'h5352_5150,
            retry_limit_hit: 1'b1, tx_fifo_full: 1'b1, wait_for_drain: 1'b0};
      ticks_to_send.push_back(t);

      // Random phases, each under its own register setting.
      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_idle();
         if (p == 6) begin
            phase_threshold[p] = 8'($urandom_range(0, 20));
            phase_per_status[p] = 3'($urandom_range(1, 7));
         end
         write_registers(phase_threshold[p], phase_per_status[p]);
         for (int i = 0; i < phase_ticks[p]; i++) begin
            t.temperature = pick_word();
            t.altitude = pick_word();
            t.pressure = pick_word();
            t.angle_x_centi = pick_word();
            t.angle_y_centi = pick_word();
            t.retry_limit_hit = 1'($urandom_range(0, 1));
            t.tx_fifo_full = 1'($urandom_range(0, 1));
            t.wait_for_drain = ($urandom_range(0, 29) == 0);
            ticks_to_send.push_back(t);
         end
      end

      wait_idle();
      repeat (40) @(negedge clock);
      $display("Sent %0d ticks under %0d register settings: %0d data and %0d status frames.",
               ticks_accepted, settings_used, data_frames, status_frames);
      $display("Checked %0d results; message number wrapped %0d times; %0d mismatches.",
               results_checked, msg_wraps, mismatch_count);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/tfs_pkg.sv
sv/tfs_req_if.sv
sv/tfs_rsp_if.sv
sv/tfs_sensor_shreg.sv
sv/tfs_frame_ctrl.sv
sv/telemetry_frame_scheduler_core.sv
bench/telemetry_frame_scheduler_core_tb.sv
